### rtl/core/vrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrt_pkg
// Shared types and constants of the voxel ray traversal block.
// ----------------------------------------------------------------------------
package vrt_pkg;

  localparam int ORG_W   = 24;
  localparam int HEAD_W  = 18;
  localparam int MAG_W   = 18;   // |heading| reaches 2^17 for the most negative code
  localparam int MULT_W  = 17;   // distance to the next boundary, Q1.16
  localparam int DIST_W  = 32;
  localparam int LIMIT_W = 28;
  localparam int CELL_W  = 6;
  localparam int COORD_W = 8;    // widest map coordinate
  localparam int FACE_W  = 3;
  localparam int PROD_W  = MAG_W + DIST_W;
  localparam int OFF_W   = PROD_W - 16;
  localparam int HP_W    = OFF_W + 2;
  localparam int DIV_STEPS = 33;

  localparam logic [DIST_W-1:0] DIST_SAT = '1;
  localparam logic signed [HP_W-1:0] HP_MAX = HP_W'(8388607);
  localparam logic signed [HP_W-1:0] HP_MIN = -HP_W'(8388608);

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_CAST  = 1'b1;

  localparam logic [FACE_W-1:0] FACE_FRONT  = 3'd0;
  localparam logic [FACE_W-1:0] FACE_BACK   = 3'd1;
  localparam logic [FACE_W-1:0] FACE_LEFT   = 3'd2;
  localparam logic [FACE_W-1:0] FACE_RIGHT  = 3'd3;
  localparam logic [FACE_W-1:0] FACE_TOP    = 3'd4;
  localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd5;

  typedef struct packed {
    logic               probe;
    logic               store;
    logic               solid;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } map_req_t;

endpackage

### rtl/core/vrt_recip.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrt_recip
// Three restoring dividers computing 2^32 / |heading|, one bit per cycle.
// ----------------------------------------------------------------------------
module vrt_recip
  import vrt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [MAG_W-1:0]  mag_in [3],
  output logic              done,
  output logic [DIST_W-1:0] delta [3]
);

  logic             running;
  logic [5:0]       cnt;
  logic [MAG_W-1:0] mag [3];
  logic [MAG_W-1:0] rem [3];
  logic [DIST_W-1:0] quo [3];   // the leading quotient bit is zero once |heading| >= 2
  logic [MAG_W-1:0] rem_next [3];
  logic             qbit [3];
  logic [MAG_W:0]   trial [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      trial[k] = {rem[k], (cnt == 6'd0)};
      qbit[k]  = trial[k] >= {1'b0, mag[k]};
      rem_next[k] = qbit[k] ? MAG_W'(trial[k] - {1'b0, mag[k]}) : trial[k][MAG_W-1:0];
      delta[k] = (mag[k] <= MAG_W'(1)) ? DIST_SAT : quo[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(DIV_STEPS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (start) begin
        mag[k] <= mag_in[k];
        rem[k] <= '0;
        quo[k] <= '0;
      end else if (running) begin
        rem[k] <= rem_next[k];
        quo[k] <= {quo[k][DIST_W-2:0], qbit[k]};
      end
    end
  end

endmodule

### rtl/core/vrt_occ_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrt_occ_map
// Occupancy map: one row of x bits per (z, y), cleared row by row after reset.
// ----------------------------------------------------------------------------
module vrt_occ_map
  import vrt_pkg::*;
#(
  parameter int WORLD_SIZE = 64
) (
  input  logic     clk,
  input  logic     rst,
  input  map_req_t req,
  output logic     busy,
  output logic     rd_bit
);

  localparam int CW   = $clog2(WORLD_SIZE);
  localparam int RAW  = 2 * CW;
  localparam int ROWS = 1 << RAW;
  localparam int XW   = 1 << CW;

  logic [XW-1:0]  mem [ROWS];
  logic [XW-1:0]  row_q;
  logic [XW-1:0]  row_mod;
  logic [RAW-1:0] rd_addr;
  logic [RAW-1:0] addr_q;
  logic [RAW-1:0] clr_addr;
  logic [CW-1:0]  x_q;
  logic           solid_q;
  logic           store_q;

  assign rd_addr = {req.z[CW-1:0], req.y[CW-1:0]};
  assign rd_bit  = row_q[x_q];

  always_comb begin
    row_mod      = row_q;
    row_mod[x_q] = solid_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
      store_q  <= 1'b0;
    end else begin
      store_q <= req.store;
      if (busy) begin
        clr_addr <= clr_addr + RAW'(1);
        if (clr_addr == RAW'(ROWS - 1)) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.probe || req.store) begin
      row_q   <= mem[rd_addr];
      addr_q  <= rd_addr;
      x_q     <= req.x[CW-1:0];
      solid_q <= req.solid;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (store_q) begin
      mem[addr_q] <= row_mod;
    end
  end

endmodule

### rtl/core/voxel_ray_traversal.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_ray_traversal
// 3D DDA voxel ray caster over an on-chip occupancy map.
// ----------------------------------------------------------------------------
// One word at a time. After reset the map is cleared one row per cycle,
// all 2^(2*ceil(log2 WORLD_SIZE)) rows (4096 at the default size), and no
// word is taken during that pass. A write word for a cell inside the world
// does a map read-modify-write of one row. A cast first runs the three
// bit-serial reciprocals and forms the start distances, then steps one
// voxel at a time, with one map read per probe inside the world, and on a
// hit forms the hit point before it loads the output register. A finished
// result sits in the output register while the next word is accepted.
// ----------------------------------------------------------------------------
module voxel_ray_traversal
  import vrt_pkg::*;
#(
  parameter int WORLD_SIZE = 64,
  parameter int MAX_STEPS  = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     mode,
  input  logic signed [ORG_W-1:0]  origin_x,
  input  logic signed [ORG_W-1:0]  origin_y,
  input  logic signed [ORG_W-1:0]  origin_z,
  input  logic signed [HEAD_W-1:0] heading_x,
  input  logic signed [HEAD_W-1:0] heading_y,
  input  logic signed [HEAD_W-1:0] heading_z,
  input  logic [LIMIT_W-1:0]       length_limit,
  input  logic [CELL_W-1:0]        cell_x,
  input  logic [CELL_W-1:0]        cell_y,
  input  logic [CELL_W-1:0]        cell_z,
  input  logic                     solid,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     hit,
  output logic [CELL_W-1:0]        hit_cell_x,
  output logic [CELL_W-1:0]        hit_cell_y,
  output logic [CELL_W-1:0]        hit_cell_z,
  output logic [FACE_W-1:0]        entry_face,
  output logic signed [ORG_W-1:0]  hit_point_x,
  output logic signed [ORG_W-1:0]  hit_point_y,
  output logic signed [ORG_W-1:0]  hit_point_z
);

  localparam int SW  = $clog2(MAX_STEPS + 1);
  localparam int CCW = 9 + SW;   // start cell +-128 plus every possible step
  localparam logic signed [CCW-1:0] WS_S = CCW'(WORLD_SIZE);
  localparam logic [8:0] WS9 = 9'(WORLD_SIZE);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_WREQ  = 9'b000000010,
    S_WWAIT = 9'b000000100,
    S_DIV   = 9'b000001000,
    S_SIDE  = 9'b000010000,
    S_WALK  = 9'b000100000,
    S_PROBE = 9'b001000000,
    S_HITPT = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_t;

  state_t state;

  // Latched word
  logic signed [ORG_W-1:0]  org  [3];
  logic signed [HEAD_W-1:0] head [3];
  logic [LIMIT_W-1:0]       limit;
  logic [CELL_W-1:0]        wcell [3];
  logic                     wsolid;

  // Walk state
  logic signed [CCW-1:0] pos [3];
  logic [DIST_W-1:0]     side [3];
  logic [DIST_W-1:0]     delta_q [3];
  logic [DIST_W-1:0]     walked;
  logic                  entered;
  logic [FACE_W-1:0]     face;
  logic [SW-1:0]         steps;
  logic [1:0]            lane;
  logic [PROD_W-1:0]     prod;

  // Result held until the output register frees
  logic                    res_hit;
  logic [CELL_W-1:0]       res_cell [3];
  logic [FACE_W-1:0]       res_face;
  logic signed [ORG_W-1:0] res_hp [3];

  logic              accept;
  logic              map_busy;
  logic              map_bit;
  map_req_t          map_req;
  logic              div_done;
  logic [MAG_W-1:0]  mag_in [3];
  logic [DIST_W-1:0] delta_c [3];
  logic [MAG_W-1:0]  mag [3];
  logic              in_world;
  logic              wr_ok;
  logic [1:0]        ax;
  logic [1:0]        li;
  logic [1:0]        lp;
  logic [MAG_W-1:0]  mul_a;
  logic [DIST_W-1:0] mul_b;
  logic [MULT_W-1:0] side_mult [3];
  logic [OFF_W-1:0]  side_p;
  logic [DIST_W-1:0] side_val;
  logic [OFF_W-1:0]  off;
  logic signed [HP_W-1:0] hp_sum;
  logic signed [ORG_W-1:0] hp_sat;
  logic [DIST_W:0]   sat_sum;
  logic [DIST_W-1:0] side_stepped;
  logic              go_probe;
  logic              walk_end;

  assign in_ready = (state == S_IDLE) && !map_busy;
  assign accept   = in_valid && in_ready;

  assign mag_in[0] = (heading_x < 0) ? MAG_W'(-heading_x) : MAG_W'(heading_x);
  assign mag_in[1] = (heading_y < 0) ? MAG_W'(-heading_y) : MAG_W'(heading_y);
  assign mag_in[2] = (heading_z < 0) ? MAG_W'(-heading_z) : MAG_W'(heading_z);

  vrt_recip u_recip (
    .clk    (clk),
    .rst    (rst),
    .start  (accept && (mode == MODE_CAST)),
    .mag_in (mag_in),
    .done   (div_done),
    .delta  (delta_c)
  );

  vrt_occ_map #(.WORLD_SIZE(WORLD_SIZE)) u_map (
    .clk    (clk),
    .rst    (rst),
    .req    (map_req),
    .busy   (map_busy),
    .rd_bit (map_bit)
  );

  always_comb begin
    in_world = 1'b1;
    for (int k = 0; k < 3; k++) begin
      mag[k] = (head[k] < 0) ? MAG_W'(-head[k]) : MAG_W'(head[k]);
      side_mult[k] = (head[k] < 0) ? {1'b0, org[k][15:0]}
                                   : MULT_W'(17'h10000 - {1'b0, org[k][15:0]});
      if (pos[k][CCW-1] || !(pos[k] < WS_S)) in_world = 1'b0;
    end
    wr_ok = ({3'b0, wcell[0]} < WS9) && ({3'b0, wcell[1]} < WS9) &&
            ({3'b0, wcell[2]} < WS9);
  end

  // Smallest side distance; ties favor z, then y
  always_comb begin
    if (side[2] <= side[0] && side[2] <= side[1]) ax = 2'd2;
    else if (side[1] <= side[0])                  ax = 2'd1;
    else                                          ax = 2'd0;
    sat_sum = {1'b0, side[ax]} + {1'b0, delta_q[ax]};
    side_stepped = (side[ax] == DIST_SAT || delta_q[ax] == DIST_SAT || sat_sum[DIST_W])
                   ? DIST_SAT : sat_sum[DIST_W-1:0];
  end

  assign walk_end = (steps == SW'(MAX_STEPS)) || (walked > {4'b0, limit});
  assign go_probe = (state == S_WALK) && !walk_end && in_world;

  always_comb begin
    map_req       = '0;
    map_req.probe = go_probe;
    map_req.store = (state == S_WREQ) && wr_ok;
    if (state == S_WREQ) begin
      map_req.solid = wsolid;
      map_req.x     = COORD_W'(wcell[0]);
      map_req.y     = COORD_W'(wcell[1]);
      map_req.z     = COORD_W'(wcell[2]);
    end else begin
      map_req.x = pos[0][COORD_W-1:0];
      map_req.y = pos[1][COORD_W-1:0];
      map_req.z = pos[2][COORD_W-1:0];
    end
  end

  // Shared multiplier: feed lane li, consume the registered product of lane lp in the following cycle
  assign li = (lane == 2'd3) ? 2'd2 : lane;
  assign lp = (lane == 2'd0) ? 2'd0 : lane - 2'd1;

  always_comb begin
    if (state == S_HITPT) begin
      mul_a = mag[li];
      mul_b = walked;
    end else begin
      mul_a = MAG_W'(side_mult[li]);
      mul_b = delta_q[li];
    end
    side_p = prod[PROD_W-1:16];
    if (delta_q[lp] == DIST_SAT)
      side_val = (side_mult[lp] != '0) ? DIST_SAT : '0;
    else
      side_val = (side_p > OFF_W'(DIST_SAT)) ? DIST_SAT : side_p[DIST_W-1:0];
    off    = prod[PROD_W-1:16];
    hp_sum = (head[lp] < 0) ? HP_W'(org[lp]) - $signed({2'b0, off})
                            : HP_W'(org[lp]) + $signed({2'b0, off});
    if (hp_sum > HP_MAX)      hp_sat = ORG_W'(HP_MAX);
    else if (hp_sum < HP_MIN) hp_sat = ORG_W'(HP_MIN);
    else                      hp_sat = hp_sum[ORG_W-1:0];
  end

  always_ff @(posedge clk) begin
    prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // Latch the word on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      org[0]   <= origin_x;
      org[1]   <= origin_y;
      org[2]   <= origin_z;
      head[0]  <= heading_x;
      head[1]  <= heading_y;
      head[2]  <= heading_z;
      limit    <= length_limit;
      wcell[0] <= cell_x;
      wcell[1] <= cell_y;
      wcell[2] <= cell_z;
      wsolid   <= solid;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      steps   <= '0;
      lane    <= '0;
      entered <= 1'b0;
      walked  <= '0;
      face    <= FACE_FRONT;
      for (int k = 0; k < 3; k++) begin
        pos[k]     <= '0;
        side[k]    <= '0;
        delta_q[k] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (mode == MODE_CAST) begin
              pos[0]  <= {{(CCW-8){origin_x[23]}}, origin_x[23:16]};
              pos[1]  <= {{(CCW-8){origin_y[23]}}, origin_y[23:16]};
              pos[2]  <= {{(CCW-8){origin_z[23]}}, origin_z[23:16]};
              walked  <= '0;
              entered <= 1'b0;
              face    <= FACE_FRONT;
              steps   <= '0;
              state   <= S_DIV;
            end else begin
              state <= S_WREQ;
            end
          end
        end
        S_WREQ:  state <= S_WWAIT;
        S_WWAIT: state <= S_IDLE;  // map writes the row back here
        S_DIV: begin
          if (div_done) begin
            for (int k = 0; k < 3; k++) delta_q[k] <= delta_c[k];
            lane  <= '0;
            state <= S_SIDE;
          end
        end
        S_SIDE: begin
          if (lane != 2'd0) side[lp] <= side_val;
          lane <= lane + 2'd1;
          if (lane == 2'd3) state <= S_WALK;
        end
        S_WALK, S_PROBE: begin
          priority if (state == S_WALK && walk_end) begin
            state <= S_EMIT;
          end else if (go_probe) begin
            entered <= 1'b1;
            state   <= S_PROBE;
          end else if (state == S_WALK && entered) begin
            state <= S_EMIT;
          end else if (state == S_PROBE && map_bit) begin
            lane  <= '0;
            state <= S_HITPT;
          end else begin
            // advance one voxel along the nearest boundary
            walked   <= side[ax];
            side[ax] <= side_stepped;
            steps    <= steps + SW'(1);
            pos[ax]  <= (head[ax] < 0) ? pos[ax] - CCW'(1) : pos[ax] + CCW'(1);
            unique case (ax)
              2'd0:    face <= (head[0] < 0) ? FACE_RIGHT : FACE_LEFT;
              2'd1:    face <= (head[1] < 0) ? FACE_TOP : FACE_BOTTOM;
              default: face <= (head[2] < 0) ? FACE_BACK : FACE_FRONT;
            endcase
            state <= S_WALK;
          end
        end
        S_HITPT: begin
          lane <= lane + 2'd1;
          if (lane == 2'd3) state <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result capture: cleared at the start of every cast, filled on a hit
  always_ff @(posedge clk) begin
    if (state == S_DIV) begin
      res_hit  <= 1'b0;
      res_face <= FACE_FRONT;
      for (int k = 0; k < 3; k++) begin
        res_cell[k] <= '0;
        res_hp[k]   <= '0;
      end
    end else if (state == S_PROBE && map_bit) begin
      res_hit  <= 1'b1;
      res_face <= face;
      for (int k = 0; k < 3; k++) res_cell[k] <= pos[k][CELL_W-1:0];
    end else if (state == S_HITPT && lane != 2'd0) begin
      res_hp[lp] <= hp_sat;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && (!out_valid || out_ready)) begin
      hit         <= res_hit;
      hit_cell_x  <= res_cell[0];
      hit_cell_y  <= res_cell[1];
      hit_cell_z  <= res_cell[2];
      entry_face  <= res_face;
      hit_point_x <= res_hp[0];
      hit_point_y <= res_hp[1];
      hit_point_z <= res_hp[2];
    end
  end

  // No word is taken while the map clear runs
  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    map_busy |-> !in_ready) else $error("word accepted during map clear");

  // A miss carries all-zero fields
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hit) |-> (hit_cell_x == '0 && hit_cell_y == '0 &&
      hit_cell_z == '0 && entry_face == FACE_FRONT && hit_point_x == '0 &&
      hit_point_y == '0 && hit_point_z == '0)) else $error("miss with data");

  // The step count never runs past its bound
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    steps <= SW'(MAX_STEPS)) else $error("step count overrun");

endmodule
